// ----- design/cnnp_pkg.sv -----
// Shared widths, register map and types of the control net negative projection block.
package cnnp_pkg;

    localparam int COORD_BITS     = 32;
    localparam int MAX_ROW_POINTS = 1024;
    localparam int COL_BITS       = $clog2(MAX_ROW_POINTS);
    localparam int LEN_BITS       = 11;
    localparam int REF_BITS       = 18;
    localparam int TOL_BITS       = 52;
    localparam int DIFF_BITS      = COORD_BITS + 1;
    localparam int PROD_BITS      = DIFF_BITS + REF_BITS;
    localparam int CMP_BITS       = ((PROD_BITS + 2 > TOL_BITS + 1) ?
                                     (PROD_BITS + 2) : (TOL_BITS + 1)) + 1;
    localparam int POINT_BITS     = 3 * COORD_BITS;
    localparam int DATA_BITS      = 64;
    localparam int ADDR_BITS      = 6;
    localparam int IDX_BITS       = 3;

    localparam logic [LEN_BITS-1:0] MAX_LEN = LEN_BITS'(MAX_ROW_POINTS);

    localparam logic [IDX_BITS-1:0] REG_ROW_LENGTH = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_REF_U_X    = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_REF_U_Y    = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_REF_U_Z    = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_REF_V_X    = 3'd4;
    localparam logic [IDX_BITS-1:0] REG_REF_V_Y    = 3'd5;
    localparam logic [IDX_BITS-1:0] REG_REF_V_Z    = 3'd6;
    localparam logic [IDX_BITS-1:0] REG_TOLERANCE  = 3'd7;

    typedef struct packed {
        logic        [LEN_BITS-1:0] row_length;
        logic signed [REF_BITS-1:0] ref_u_x;
        logic signed [REF_BITS-1:0] ref_u_y;
        logic signed [REF_BITS-1:0] ref_u_z;
        logic signed [REF_BITS-1:0] ref_v_x;
        logic signed [REF_BITS-1:0] ref_v_y;
        logic signed [REF_BITS-1:0] ref_v_z;
        logic        [TOL_BITS-1:0] tolerance;
    } cfg_t;

    typedef struct packed {
        logic valid;
        logic last;
        logic check_u;
        logic check_v;
    } tag_t;

    typedef struct packed {
        logic valid;
        logic last;
        logic negative;
    } res_t;

endpackage

// ----- design/control_net_negative_projection.sv -----
// Top level of the control net negative projection block.
//
// Control points enter on s_axis one item per cycle unless stalled, row-major with
// u fastest; s_axis_tlast marks a surface's last point. Each point is compared with
// its left neighbour against the u reference vector and with the point above,
// read from the line buffer, against the v reference vector. On the last point
// one item leaves on m_axis: bit 0 is set if any projection lay strictly below
// minus the tolerance. Points not marked last give no result.
// Throughput: one point per cycle unless m_axis stalls, set by the single line
// buffer port, which reads the point above and writes the new point in the same cycle.
// The result passes the line buffer read, difference, multiply, and sum and
// compare stages and then the output register. A stalled m_axis holds its item;
// the pipeline then freezes and s_axis_tready drops until the item is taken.
// Reset clears the pipeline, the column count and the flag and sets the register
// defaults; the line buffer needs no clearing as no check uses first-row reads.
// Registers are to be written over APB only while idle; the block does not enforce it.
module control_net_negative_projection
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [cnnp_pkg::POINT_BITS-1:0] s_axis_tdata,  // coord_x, coord_y, coord_z
    input  logic                           s_axis_tlast,  // last_point
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [7:0]                     m_axis_tdata,  // negative_found, zero fill
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cnnp_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [cnnp_pkg::DATA_BITS-1:0]  pwdata,
    output logic [cnnp_pkg::DATA_BITS-1:0]  prdata,
    output logic                           pready
);
    import cnnp_pkg::*;

    cfg_t                  cfg;
    tag_t                  in_tag;
    res_t                  res;
    logic                  advance;
    logic                  accept;
    logic [POINT_BITS-1:0] above;
    logic [LEN_BITS-1:0]   len_eff;
    logic [LEN_BITS-1:0]   col_inc;
    logic [COL_BITS-1:0]   col_reg, col_next;
    logic                  first_row_reg, first_row_next;
    logic                  sticky_reg, sticky_next;
    logic [POINT_BITS-1:0] left_reg;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_flag_reg, out_flag_next;
    logic                  merged;

    cnnp_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cnnp_line_buf u_line_buf
    (
        .clk     (clk),
        .en      (accept),
        .addr    (col_reg),
        .wr_data (s_axis_tdata),
        .rd_data (above)
    );

    cnnp_proj u_proj
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .cfg      (cfg),
        .in_tag   (in_tag),
        .in_point (s_axis_tdata),
        .in_left  (left_reg),
        .above    (above),
        .res      (res)
    );

    assign advance       = !(out_valid_reg && !m_axis_tready);
    assign s_axis_tready = advance;
    assign accept        = s_axis_tvalid && advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_flag_reg};

    assign in_tag.valid   = accept;
    assign in_tag.last    = s_axis_tlast;
    assign in_tag.check_u = (col_reg != '0);
    assign in_tag.check_v = !first_row_reg;

    always_comb
    begin
        if (cfg.row_length == '0)
            len_eff = LEN_BITS'(1);
        else if (cfg.row_length > MAX_LEN)
            len_eff = MAX_LEN;
        else
            len_eff = cfg.row_length;
        col_inc = LEN_BITS'(col_reg) + LEN_BITS'(1);

        col_next       = col_reg;
        first_row_next = first_row_reg;
        if (accept)
        begin
            if (s_axis_tlast)
            begin
                col_next       = '0;
                first_row_next = 1'b1;
            end
            else if (col_inc >= len_eff)
            begin
                col_next       = '0;
                first_row_next = 1'b0;
            end
            else
            begin
                col_next = col_inc[COL_BITS-1:0];
            end
        end

        merged         = sticky_reg || res.negative;
        sticky_next    = sticky_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_flag_next  = out_flag_reg;
        if (advance && res.valid)
        begin
            if (res.last)
            begin
                sticky_next    = 1'b0;
                out_valid_next = 1'b1;
                out_flag_next  = merged;
            end
            else
            begin
                sticky_next = merged;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            first_row_reg <= 1'b1;
            sticky_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            first_row_reg <= first_row_next;
            sticky_reg    <= sticky_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_flag_reg <= out_flag_next;
        if (accept)
            left_reg <= s_axis_tdata;
    end

`ifndef NO_ASSERTIONS
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_axis_tlast) |=> (col_reg == '0 && first_row_reg))
        else $error("column state not cleared after last point");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(res.valid && res.last))
        else $error("result without a last point leaving the pipeline");

    a_sticky_clr: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res.valid && res.last) |=> !sticky_reg)
        else $error("flag not cleared after result");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(col_reg) && $stable(sticky_reg))
        else $error("state moved while output stalled");
`endif

endmodule

// ----- design/cnnp_cfg.sv -----
// APB register file holding row length, reference vectors and tolerance.
module cnnp_cfg
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cnnp_pkg::ADDR_BITS-1:0] paddr,
    input  logic [cnnp_pkg::DATA_BITS-1:0] pwdata,
    output logic [cnnp_pkg::DATA_BITS-1:0] prdata,
    output logic                          pready,
    output cnnp_pkg::cfg_t                cfg
);
    import cnnp_pkg::*;

    cfg_t                cfg_reg;
    cfg_t                cfg_next;
    logic [IDX_BITS-1:0] idx;
    logic                wr;

    assign idx    = paddr[ADDR_BITS-1:ADDR_BITS-IDX_BITS];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            case (idx)
                REG_ROW_LENGTH: cfg_next.row_length = pwdata[LEN_BITS-1:0];
                REG_REF_U_X:    cfg_next.ref_u_x    = pwdata[REF_BITS-1:0];
                REG_REF_U_Y:    cfg_next.ref_u_y    = pwdata[REF_BITS-1:0];
                REG_REF_U_Z:    cfg_next.ref_u_z    = pwdata[REF_BITS-1:0];
                REG_REF_V_X:    cfg_next.ref_v_x    = pwdata[REF_BITS-1:0];
                REG_REF_V_Y:    cfg_next.ref_v_y    = pwdata[REF_BITS-1:0];
                REG_REF_V_Z:    cfg_next.ref_v_z    = pwdata[REF_BITS-1:0];
                REG_TOLERANCE:  cfg_next.tolerance  = pwdata[TOL_BITS-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_ROW_LENGTH: prdata = DATA_BITS'(cfg_reg.row_length);
            REG_REF_U_X:    prdata = DATA_BITS'($unsigned(cfg_reg.ref_u_x));
            REG_REF_U_Y:    prdata = DATA_BITS'($unsigned(cfg_reg.ref_u_y));
            REG_REF_U_Z:    prdata = DATA_BITS'($unsigned(cfg_reg.ref_u_z));
            REG_REF_V_X:    prdata = DATA_BITS'($unsigned(cfg_reg.ref_v_x));
            REG_REF_V_Y:    prdata = DATA_BITS'($unsigned(cfg_reg.ref_v_y));
            REG_REF_V_Z:    prdata = DATA_BITS'($unsigned(cfg_reg.ref_v_z));
            REG_TOLERANCE:  prdata = DATA_BITS'(cfg_reg.tolerance);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= cfg_t'({LEN_BITS'(1), {($bits(cfg_t)-LEN_BITS){1'b0}}});
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- design/cnnp_line_buf.sv -----
// Line buffer holding the previous row of control points, read-first, with a registered read.
module cnnp_line_buf
(
    input  logic                           clk,
    input  logic                           en,
    input  logic [cnnp_pkg::COL_BITS-1:0]   addr,
    input  logic [cnnp_pkg::POINT_BITS-1:0] wr_data,
    output logic [cnnp_pkg::POINT_BITS-1:0] rd_data
);
    import cnnp_pkg::*;

    logic [POINT_BITS-1:0] line_mem [MAX_ROW_POINTS];
    logic [POINT_BITS-1:0] rd_data_reg;

    assign rd_data = rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd_data_reg    <= line_mem[addr];
            line_mem[addr] <= wr_data;
        end
    end

endmodule

// ----- design/cnnp_proj.sv -----
// Projection pipeline: differences, products with the reference vectors, tolerance compare.
module cnnp_proj
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  cnnp_pkg::cfg_t                 cfg,
    input  cnnp_pkg::tag_t                 in_tag,
    input  logic [cnnp_pkg::POINT_BITS-1:0] in_point,
    input  logic [cnnp_pkg::POINT_BITS-1:0] in_left,
    input  logic [cnnp_pkg::POINT_BITS-1:0] above,
    output cnnp_pkg::res_t                 res
);
    import cnnp_pkg::*;

    tag_t                        tag1_reg, tag2_reg, tag3_reg;
    res_t                        res4_reg;
    logic [POINT_BITS-1:0]       point1_reg;
    logic [POINT_BITS-1:0]       left1_reg;
    logic signed [DIFF_BITS-1:0] du2_reg [3];
    logic signed [DIFF_BITS-1:0] dv2_reg [3];
    logic signed [PROD_BITS-1:0] pu3_reg [3];
    logic signed [PROD_BITS-1:0] pv3_reg [3];
    logic signed [DIFF_BITS-1:0] du_next [3];
    logic signed [DIFF_BITS-1:0] dv_next [3];
    logic signed [REF_BITS-1:0]  ref_u [3];
    logic signed [REF_BITS-1:0]  ref_v [3];
    logic signed [CMP_BITS-1:0]  sum_u;
    logic signed [CMP_BITS-1:0]  sum_v;
    logic signed [CMP_BITS-1:0]  tol_ext;

    assign ref_u[0] = cfg.ref_u_x;
    assign ref_u[1] = cfg.ref_u_y;
    assign ref_u[2] = cfg.ref_u_z;
    assign ref_v[0] = cfg.ref_v_x;
    assign ref_v[1] = cfg.ref_v_y;
    assign ref_v[2] = cfg.ref_v_z;
    assign tol_ext  = $signed({{(CMP_BITS-TOL_BITS){1'b0}}, cfg.tolerance});
    assign res      = res4_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            du_next[k] = DIFF_BITS'($signed(point1_reg[k*COORD_BITS +: COORD_BITS]))
                       - DIFF_BITS'($signed(left1_reg[k*COORD_BITS +: COORD_BITS]));
            dv_next[k] = DIFF_BITS'($signed(point1_reg[k*COORD_BITS +: COORD_BITS]))
                       - DIFF_BITS'($signed(above[k*COORD_BITS +: COORD_BITS]));
        end
        sum_u = CMP_BITS'(pu3_reg[0]) + CMP_BITS'(pu3_reg[1]) + CMP_BITS'(pu3_reg[2])
              + tol_ext;
        sum_v = CMP_BITS'(pv3_reg[0]) + CMP_BITS'(pv3_reg[1]) + CMP_BITS'(pv3_reg[2])
              + tol_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
            res4_reg <= '0;
        end
        else if (advance)
        begin
            tag1_reg          <= in_tag;
            tag2_reg          <= tag1_reg;
            tag3_reg          <= tag2_reg;
            res4_reg.valid    <= tag3_reg.valid;
            res4_reg.last     <= tag3_reg.last;
            res4_reg.negative <= (tag3_reg.check_u && sum_u[CMP_BITS-1])
                              || (tag3_reg.check_v && sum_v[CMP_BITS-1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            point1_reg <= in_point;
            left1_reg  <= in_left;
            for (int k = 0; k < 3; k++)
            begin
                du2_reg[k] <= du_next[k];
                dv2_reg[k] <= dv_next[k];
                pu3_reg[k] <= PROD_BITS'(du2_reg[k]) * PROD_BITS'(ref_u[k]);
                pv3_reg[k] <= PROD_BITS'(dv2_reg[k]) * PROD_BITS'(ref_v[k]);
            end
        end
    end

endmodule
